[hdl/srp_pkg.sv]
// ----------------------------------------------------------------------------
// srp_pkg
// types and fixed codes shared by the sysex request parser and its checker
// ----------------------------------------------------------------------------
package srp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [13:0] chunk_idx;
    } rsp_t;

    localparam logic [1:0] KIND_NONE      = 2'd0;
    localparam logic [1:0] KIND_HANDSHAKE = 2'd1;
    localparam logic [1:0] KIND_CHUNK     = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN   = 2'd3;

    localparam logic [2:0] REG_MANUFACTURER_ID  = 3'd0;
    localparam logic [2:0] REG_DEVICE_ID        = 3'd1;
    localparam logic [2:0] REG_HANDSHAKE_CODE   = 3'd2;
    localparam logic [2:0] REG_DESCRIPTOR_CODE  = 3'd3;
    localparam logic [2:0] REG_REQUEST_DIR_CODE = 3'd4;
    localparam logic [2:0] REG_HANDSHAKE_LEN    = 3'd5;
    localparam logic [2:0] REG_CHUNK_LEN        = 3'd6;
    localparam logic [2:0] REG_MAX_LEN          = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int CODE_W      = 7;
    localparam int LEN_W       = 10;
    localparam int COUNT_W     = 11;

    localparam logic [7:0] SYX_START = 8'hF0;
    localparam logic [7:0] SYX_END   = 8'hF7;

    localparam logic [COUNT_W-1:0] MIN_LEN   = 11'd6;
    localparam logic [COUNT_W-1:0] COUNT_SAT = 11'd1024;

endpackage

[hdl/sysex_request_parser_unit.sv]
// ----------------------------------------------------------------------------
// sysex_request_parser_unit
// classifies midi sysex request frames that arrive one byte per transaction
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one frame byte per transaction, frame_end set on the last
//   byte of a frame. Every byte of a frame is taken, whatever its value.
//   rsp channel: one transaction per frame, issued for the byte that carries
//   frame_end, with the request kind and, for a chunk request, its index.
//   cfg port: single-cycle register writes, done while no frame is in flight.
// Result: registered, on rsp in the cycle after the last byte is taken.
// Throughput: one byte per cycle while req_stall is low; the frame state and
//   result update in the cycle a byte is taken; frames may run back to back.
// Stall: the result register holds its transaction while rsp_stall is high;
//   req_stall rises only when that register is full and stalled, bytes that
//   do not end a frame are still held back then to keep the order simple.
// Reset: rst_n clears the frame state, empties the result register and loads
//   the register defaults; the block is ready as soon as rst_n is released.
// ----------------------------------------------------------------------------
module sysex_request_parser_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  srp_pkg::req_t                  req_data,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output srp_pkg::rsp_t                  rsp_data,
    input  logic                           cfg_write,
    input  logic [srp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [srp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import srp_pkg::*;

    logic [CODE_W-1:0] manufacturer_id_reg;
    logic [CODE_W-1:0] device_id_reg;
    logic [CODE_W-1:0] handshake_code_reg;
    logic [CODE_W-1:0] descriptor_code_reg;
    logic [CODE_W-1:0] request_dir_code_reg;
    logic [LEN_W-1:0]  handshake_len_reg;
    logic [LEN_W-1:0]  chunk_len_reg;
    logic [LEN_W-1:0]  max_len_reg;

    logic [COUNT_W-1:0] byte_count_reg;
    logic               header_ok_reg;
    logic               high_bit_seen_reg;
    logic [7:0]         block_byte_reg;
    logic [7:0]         direction_byte_reg;
    logic [6:0]         index_low_reg;
    logic [6:0]         index_high_reg;

    logic [COUNT_W-1:0] byte_count_next;
    logic               header_ok_next;
    logic               high_bit_seen_next;
    logic [7:0]         block_byte_next;
    logic [7:0]         direction_byte_next;
    logic [6:0]         index_low_next;
    logic [6:0]         index_high_next;

    logic               rsp_valid_reg;
    rsp_t               rsp_data_reg;
    rsp_t               rsp_data_next;

    logic               accept;
    logic [7:0]         b;
    logic               last;
    logic [COUNT_W-1:0] pos;
    logic [COUNT_W-1:0] len;
    logic               frame_ok;

    assign req_stall = rsp_valid_reg & rsp_stall;
    assign accept    = req_valid & ~req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    assign b    = req_data.data_byte;
    assign last = req_data.frame_end;
    assign pos  = byte_count_reg;
    assign len  = byte_count_reg + 11'd1;

    // frame state after this byte
    always_comb
    begin
        header_ok_next = header_ok_reg;
        if ((pos == 11'd0) && (b != SYX_START))
        begin
            header_ok_next = 1'b0;
        end
        if ((pos == 11'd1) && (b != {1'b0, manufacturer_id_reg}))
        begin
            header_ok_next = 1'b0;
        end
        if ((pos == 11'd2) && (b != {1'b0, device_id_reg}))
        begin
            header_ok_next = 1'b0;
        end
        block_byte_next     = (pos == 11'd3) ? b : block_byte_reg;
        direction_byte_next = (pos == 11'd4) ? b : direction_byte_reg;
        index_low_next      = (pos == 11'd5) ? b[6:0] : index_low_reg;
        index_high_next     = (pos == 11'd6) ? b[6:0] : index_high_reg;
        high_bit_seen_next  = high_bit_seen_reg | ((pos != 11'd0) & ~last & b[7]);
        byte_count_next     = (byte_count_reg != COUNT_SAT) ? len : byte_count_reg;
    end

    // classification on the closing byte
    always_comb
    begin
        frame_ok = (len >= MIN_LEN) && (len <= {1'b0, max_len_reg}) && (b == SYX_END)
                   && header_ok_next && !high_bit_seen_next
                   && (direction_byte_next == {1'b0, request_dir_code_reg});
        rsp_data_next.kind      = KIND_NONE;
        rsp_data_next.chunk_idx = '0;
        if (frame_ok)
        begin
            if (block_byte_next == {1'b0, handshake_code_reg})
            begin
                if (len == {1'b0, handshake_len_reg})
                begin
                    rsp_data_next.kind = KIND_HANDSHAKE;
                end
            end
            else if (block_byte_next == {1'b0, descriptor_code_reg})
            begin
                if (len == {1'b0, chunk_len_reg})
                begin
                    rsp_data_next.kind      = KIND_CHUNK;
                    rsp_data_next.chunk_idx = {index_high_next, index_low_next};
                end
            end
            else
            begin
                rsp_data_next.kind = KIND_UNKNOWN;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            manufacturer_id_reg  <= 7'd125;
            device_id_reg        <= 7'd0;
            handshake_code_reg   <= 7'd0;
            descriptor_code_reg  <= 7'd1;
            request_dir_code_reg <= 7'd0;
            handshake_len_reg    <= 10'd6;
            chunk_len_reg        <= 10'd8;
            max_len_reg          <= 10'd64;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MANUFACTURER_ID:  manufacturer_id_reg  <= cfg_data[CODE_W-1:0];
                REG_DEVICE_ID:        device_id_reg        <= cfg_data[CODE_W-1:0];
                REG_HANDSHAKE_CODE:   handshake_code_reg   <= cfg_data[CODE_W-1:0];
                REG_DESCRIPTOR_CODE:  descriptor_code_reg  <= cfg_data[CODE_W-1:0];
                REG_REQUEST_DIR_CODE: request_dir_code_reg <= cfg_data[CODE_W-1:0];
                REG_HANDSHAKE_LEN:    handshake_len_reg    <= cfg_data[LEN_W-1:0];
                REG_CHUNK_LEN:        chunk_len_reg        <= cfg_data[LEN_W-1:0];
                REG_MAX_LEN:          max_len_reg          <= cfg_data[LEN_W-1:0];
                default:              ;
            endcase
        end
    end

    // frame state, cleared after every closing byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg     <= '0;
            header_ok_reg      <= 1'b1;
            high_bit_seen_reg  <= 1'b0;
            block_byte_reg     <= '0;
            direction_byte_reg <= '0;
            index_low_reg      <= '0;
            index_high_reg     <= '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                byte_count_reg     <= '0;
                header_ok_reg      <= 1'b1;
                high_bit_seen_reg  <= 1'b0;
                block_byte_reg     <= '0;
                direction_byte_reg <= '0;
                index_low_reg      <= '0;
                index_high_reg     <= '0;
            end
            else
            begin
                byte_count_reg     <= byte_count_next;
                header_ok_reg      <= header_ok_next;
                high_bit_seen_reg  <= high_bit_seen_next;
                block_byte_reg     <= block_byte_next;
                direction_byte_reg <= direction_byte_next;
                index_low_reg      <= index_low_next;
                index_high_reg     <= index_high_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept && last)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

endmodule

[hdl/srp_checker.sv]
// ----------------------------------------------------------------------------
// srp_checker
// port-level checks for the sysex request parser, bound to its top level
// ----------------------------------------------------------------------------
module srp_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input srp_pkg::req_t req_data,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input srp_pkg::rsp_t rsp_data
);
    import srp_pkg::*;

    logic req_take;

    assign req_take = req_valid & ~req_stall;

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("stalled rsp transaction changed");

    // a closing byte always yields a result next cycle
    a_end_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_take && req_data.frame_end |=> rsp_valid)
        else $error("frame end without rsp transaction");

    // an inner byte never yields a result
    a_inner_no_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_take && !req_data.frame_end && !(rsp_valid && rsp_stall) |=> !rsp_valid)
        else $error("rsp transaction without frame end");

    // full and stalled result register blocks input
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |-> req_stall)
        else $error("byte taken while result register blocked");

    // index only for chunk requests
    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.kind != KIND_CHUNK) |-> rsp_data.chunk_idx == '0)
        else $error("chunk index set for non-chunk kind");

endmodule

bind sysex_request_parser_unit srp_checker u_srp_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives sysex request frames through the parser under random request idle
// and result stall, predicts the kind and chunk index of every frame and
// checks each result transaction in order; register settings change between
// phases, from the reset defaults over the extremes to random settings
// ----------------------------------------------------------------------------
module testbench;

    import srp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    class frame_scoreboard;

        logic [CODE_W-1:0]  manufacturer;
        logic [CODE_W-1:0]  device;
        logic [CODE_W-1:0]  handshake_code;
        logic [CODE_W-1:0]  descriptor_code;
        logic [CODE_W-1:0]  dir_code;
        logic [LEN_W-1:0]   handshake_len;
        logic [LEN_W-1:0]   chunk_len;
        logic [LEN_W-1:0]   max_len;

        logic [COUNT_W-1:0] seen;
        logic               header_match;
        logic               high_bit;
        logic [7:0]         block_val;
        logic [7:0]         dir_val;
        logic [6:0]         index_lo;
        logic [6:0]         index_hi;

        rsp_t               expected_kinds[$];
        int                 errors;

        function new();
            manufacturer    = 7'd125;
            device          = 7'd0;
            handshake_code  = 7'd0;
            descriptor_code = 7'd1;
            dir_code        = 7'd0;
            handshake_len   = 10'd6;
            chunk_len       = 10'd8;
            max_len         = 10'd64;
            errors          = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            seen         = '0;
            header_match = 1'b1;
            high_bit     = 1'b0;
            block_val    = '0;
            dir_val      = '0;
            index_lo     = '0;
            index_hi     = '0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_MANUFACTURER_ID:  manufacturer    = val[CODE_W-1:0];
                REG_DEVICE_ID:        device          = val[CODE_W-1:0];
                REG_HANDSHAKE_CODE:   handshake_code  = val[CODE_W-1:0];
                REG_DESCRIPTOR_CODE:  descriptor_code = val[CODE_W-1:0];
                REG_REQUEST_DIR_CODE: dir_code        = val[CODE_W-1:0];
                REG_HANDSHAKE_LEN:    handshake_len   = val[LEN_W-1:0];
                REG_CHUNK_LEN:        chunk_len       = val[LEN_W-1:0];
                REG_MAX_LEN:          max_len         = val[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_byte(req_t item);
            logic [7:0]         b;
            logic [COUNT_W-1:0] len;
            rsp_t               res;
            b   = item.data_byte;
            len = seen + 11'd1;
            if (seen == 0 && b != SYX_START) header_match = 1'b0;
            if (seen == 1 && b != {1'b0, manufacturer}) header_match = 1'b0;
            if (seen == 2 && b != {1'b0, device}) header_match = 1'b0;
            if (seen == 3) block_val = b;
            if (seen == 4) dir_val = b;
            if (seen == 5) index_lo = b[6:0];
            if (seen == 6) index_hi = b[6:0];
            if (seen >= 1 && !item.frame_end && b[7]) high_bit = 1'b1;
            if (seen < COUNT_SAT) seen = seen + 11'd1;
            if (item.frame_end)
            begin
                res.kind      = KIND_NONE;
                res.chunk_idx = '0;
                if (len >= MIN_LEN && len <= {1'b0, max_len} && b == SYX_END &&
                    header_match && !high_bit && dir_val == {1'b0, dir_code})
                begin
                    if (block_val == {1'b0, handshake_code})
                    begin
                        if (len == {1'b0, handshake_len}) res.kind = KIND_HANDSHAKE;
                    end
                    else if (block_val == {1'b0, descriptor_code})
                    begin
                        if (len == {1'b0, chunk_len})
                        begin
                            res.kind      = KIND_CHUNK;
                            res.chunk_idx = {index_hi, index_lo};
                        end
                    end
                    else
                    begin
                        res.kind = KIND_UNKNOWN;
                    end
                end
                expected_kinds.push_back(res);
                clear_frame();
            end
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) $display("mismatch at %0t: %s", $time, msg);
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (expected_kinds.size() == 0)
            begin
                report($sformatf("unexpected transaction kind %0d index %0d",
                                 got.kind, got.chunk_idx));
            end
            else
            begin
                want = expected_kinds.pop_front();
                if (got.kind !== want.kind || got.chunk_idx !== want.chunk_idx)
                    report($sformatf("kind exp %0d got %0d, index exp %0d got %0d",
                                     want.kind, got.kind, want.chunk_idx,
                                     got.chunk_idx));
            end
        endfunction

        function int pending();
            return expected_kinds.size();
        endfunction

    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   req_valid;
    logic                   req_stall;
    req_t                   req_data;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    rsp_t                   rsp_data;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    frame_scoreboard        sb;
    logic [CFG_DATA_W-1:0]  reg_val [8];
    logic [7:0]             frame_bytes[$];
    int                     idle_pct = 7;
    int                     quiet_cycles = 0;

    sysex_request_parser_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // result side: check, random stall, watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
            rsp_stall <= ($urandom_range(0, 99) < idle_pct);
            if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= '{data_byte: b, frame_end: last};
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sb.note_byte(req_data);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    task automatic make_frame(input int len, input logic [7:0] blk, input logic [7:0] dir);
        frame_bytes.delete();
        for (int i = 0; i < len; i++)
        begin
            case (i)
                0:       frame_bytes.push_back(SYX_START);
                1:       frame_bytes.push_back({1'b0, reg_val[REG_MANUFACTURER_ID][6:0]});
                2:       frame_bytes.push_back({1'b0, reg_val[REG_DEVICE_ID][6:0]});
                3:       frame_bytes.push_back(blk);
                4:       frame_bytes.push_back(dir);
                default: frame_bytes.push_back({1'b0, 7'($urandom_range(0, 127))});
            endcase
        end
        frame_bytes[len-1] = SYX_END;
    endtask

    // register writes carry random upper bits on the 7-bit codes
    task automatic apply_config();
        logic [CFG_DATA_W-1:0] wdata;
        for (int i = 0; i < 8; i++)
        begin
            wdata = (i < REG_HANDSHAKE_LEN) ?
                    {3'($urandom_range(0, 7)), reg_val[i][6:0]} : reg_val[i];
            cfg_write <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= wdata;
            @(posedge clk);
            sb.write_reg(3'(i), wdata);
        end
        cfg_write <= 1'b0;
    endtask

    task automatic wait_drain();
        req_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_config();
        reg_val[REG_MANUFACTURER_ID]  = 10'($urandom_range(0, 127));
        reg_val[REG_DEVICE_ID]        = 10'($urandom_range(0, 127));
        reg_val[REG_HANDSHAKE_CODE]   = 10'($urandom_range(0, 127));
        reg_val[REG_DESCRIPTOR_CODE]  = ($urandom_range(0, 7) == 0) ?
                                        reg_val[REG_HANDSHAKE_CODE] :
                                        10'($urandom_range(0, 127));
        reg_val[REG_REQUEST_DIR_CODE] = 10'($urandom_range(0, 127));
        reg_val[REG_HANDSHAKE_LEN]    = ($urandom_range(0, 9) == 0) ?
                                        10'($urandom_range(0, 5)) :
                                        10'($urandom_range(6, 12));
        reg_val[REG_CHUNK_LEN]        = ($urandom_range(0, 9) == 0) ?
                                        10'($urandom_range(0, 5)) :
                                        10'($urandom_range(6, 10));
        reg_val[REG_MAX_LEN]          = ($urandom_range(0, 9) == 0) ?
                                        10'($urandom_range(0, 9)) :
                                        10'($urandom_range(10, 40));
    endtask

    task automatic random_frame();
        int         sel;
        int         len;
        int         pos;
        logic [7:0] blk;
        logic [7:0] dir;
        sel = $urandom_range(0, 99);
        if (sel < 15)
        begin
            frame_bytes.delete();
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom));
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    blk = {1'b0, reg_val[REG_HANDSHAKE_CODE][6:0]};
                    len = reg_val[REG_HANDSHAKE_LEN];
                end
                1:
                begin
                    blk = {1'b0, reg_val[REG_DESCRIPTOR_CODE][6:0]};
                    len = reg_val[REG_CHUNK_LEN];
                end
                2:
                begin
                    blk = {1'b0, 7'($urandom_range(0, 127))};
                    len = $urandom_range(4, 16);
                end
                default:
                begin
                    blk = $urandom_range(0, 1) ? {1'b0, reg_val[REG_HANDSHAKE_CODE][6:0]} :
                                                 {1'b0, reg_val[REG_DESCRIPTOR_CODE][6:0]};
                    len = $urandom_range(1, 14);
                end
            endcase
            if (len < 1) len = 1;
            dir = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                                                {1'b0, reg_val[REG_REQUEST_DIR_CODE][6:0]};
            make_frame(len, blk, dir);
            if (sel < 30)
            begin
                pos = $urandom_range(0, frame_bytes.size() - 1);
                case ($urandom_range(0, 2))
                    0:       frame_bytes[pos] = frame_bytes[pos] ^ 8'h80;
                    1:       frame_bytes[pos] = 8'($urandom);
                    default: frame_bytes[pos] = frame_bytes[pos] ^ 8'(1 << $urandom_range(0, 7));
                endcase
            end
        end
        send_frame();
    endtask

    initial
    begin
        int sent;
        sb        = new();
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        reg_val[REG_MANUFACTURER_ID]  = 10'd125;
        reg_val[REG_DEVICE_ID]        = 10'd0;
        reg_val[REG_HANDSHAKE_CODE]   = 10'd0;
        reg_val[REG_DESCRIPTOR_CODE]  = 10'd1;
        reg_val[REG_REQUEST_DIR_CODE] = 10'd0;
        reg_val[REG_HANDSHAKE_LEN]    = 10'd6;
        reg_val[REG_CHUNK_LEN]        = 10'd8;
        reg_val[REG_MAX_LEN]          = 10'd64;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults
        make_frame(6, 8'h00, 8'h00);
        send_frame();
        make_frame(8, 8'h01, 8'h00);
        frame_bytes[5] = 8'h7F;
        frame_bytes[6] = 8'h7F;
        send_frame();
        make_frame(8, 8'h01, 8'h00);
        frame_bytes[5] = 8'h00;
        frame_bytes[6] = 8'h00;
        send_frame();
        make_frame(10, 8'h05, 8'h00);
        send_frame();
        make_frame(7, 8'h00, 8'h00);
        send_frame();
        make_frame(64, 8'h22, 8'h00);
        send_frame();
        make_frame(65, 8'h22, 8'h00);
        send_frame();
        make_frame(6, 8'h00, 8'h01);
        send_frame();
        make_frame(6, 8'h00, 8'h00);
        frame_bytes[2] = frame_bytes[2] | 8'h80;
        send_frame();
        make_frame(1, 8'h00, 8'h00);
        send_frame();
        wait_drain();

        // upper extremes and a frame above the default max length
        reg_val[REG_MANUFACTURER_ID]  = 10'd127;
        reg_val[REG_DEVICE_ID]        = 10'd127;
        reg_val[REG_HANDSHAKE_CODE]   = 10'd127;
        reg_val[REG_DESCRIPTOR_CODE]  = 10'd0;
        reg_val[REG_REQUEST_DIR_CODE] = 10'd127;
        reg_val[REG_HANDSHAKE_LEN]    = 10'd1023;
        reg_val[REG_CHUNK_LEN]        = 10'd7;
        reg_val[REG_MAX_LEN]          = 10'd1023;
        apply_config();
        make_frame(70, 8'h22, 8'h7F);
        send_frame();
        make_frame(7, 8'h00, 8'h7F);
        send_frame();
        make_frame(12, 8'h7F, 8'h7F);
        send_frame();
        wait_drain();

        // short chunk frame, handshake length below six, tight max length
        reg_val[REG_MANUFACTURER_ID]  = 10'd0;
        reg_val[REG_DEVICE_ID]        = 10'd0;
        reg_val[REG_HANDSHAKE_CODE]   = 10'd0;
        reg_val[REG_DESCRIPTOR_CODE]  = 10'd127;
        reg_val[REG_REQUEST_DIR_CODE] = 10'd0;
        reg_val[REG_HANDSHAKE_LEN]    = 10'd5;
        reg_val[REG_CHUNK_LEN]        = 10'd6;
        reg_val[REG_MAX_LEN]          = 10'd6;
        apply_config();
        make_frame(6, 8'h7F, 8'h00);
        send_frame();
        make_frame(5, 8'h00, 8'h00);
        send_frame();
        make_frame(6, 8'h40, 8'h00);
        send_frame();
        make_frame(7, 8'h40, 8'h00);
        send_frame();
        wait_drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            random_config();
            apply_config();
            idle_pct = (phase == 2) ? 0 : 7;
            sent = 0;
            while (sent < 50)
            begin
                random_frame();
                sent += frame_bytes.size();
            end
            wait_drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
